// File: src/rbst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_pkg
// types, constants and fixed-point helpers for the ray/box slope test
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int CB = 32;                 // coordinate width
  localparam int FB = 16;                 // fractional bits
  localparam int MW = 2 * CB - FB;        // product after the fraction shift
  localparam int QW = 2 * FB + 1;         // reciprocal quotient width
  localparam int NAX = 3;
  localparam int NPR = 6;
  localparam int AW = 5;                  // apb address width

  typedef logic signed [CB-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};

  typedef enum logic [1:0] {
    SG_M = 2'd0,
    SG_O = 2'd1,
    SG_P = 2'd2
  } sgn_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SMUL,
    ST_IMUL,
    ST_ISUB
  } drv_state_t;

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } box_t;

  typedef struct packed {
    logic   hit;
    coord_t entry_distance;
  } res_t;

  typedef struct packed {
    logic            neg;
    logic [2*CB-1:0] p;
  } prod_t;

  // ordered axis pairs xy, yx, zy, yz, xz, zx
  function automatic logic [1:0] pair_i(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      3'd4:    r = 2'd0;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_j(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd0;
      3'd2:    r = 2'd1;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CB-1:0] mag(input coord_t a);
    logic [CB-1:0] u;
    u = a;
    return u[CB-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic prod_t mul_q(input coord_t a, input coord_t b);
    prod_t r;
    logic [2*CB-1:0] ea;
    logic [2*CB-1:0] eb;
    ea = {{CB{1'b0}}, mag(a)};
    eb = {{CB{1'b0}}, mag(b)};
    r.neg = a[CB-1] ^ b[CB-1];
    r.p = ea * eb;
    return r;
  endfunction

  function automatic coord_t sat_mag(input logic neg, input logic [MW-1:0] m);
    coord_t r;
    if (m > MW'(CMAX)) r = neg ? CMIN : CMAX;
    else if (neg)      r = -coord_t'(m[CB-1:0]);
    else               r = coord_t'(m[CB-1:0]);
    return r;
  endfunction

  function automatic coord_t prod_sat(input prod_t x);
    return sat_mag(x.neg, x.p[2*CB-1:FB]);
  endfunction

  function automatic coord_t sadd(input coord_t a, input coord_t b);
    logic signed [CB:0] s;
    s = {a[CB-1], a} + {b[CB-1], b};
    if (s[CB] != s[CB-1]) return s[CB] ? CMIN : CMAX;
    return s[CB-1:0];
  endfunction

  function automatic coord_t ssub(input coord_t a, input coord_t b);
    logic signed [CB:0] s;
    s = {a[CB-1], a} - {b[CB-1], b};
    if (s[CB] != s[CB-1]) return s[CB] ? CMIN : CMAX;
    return s[CB-1:0];
  endfunction

endpackage

// File: src/ray_box_slope_test.sv
`timescale 1ns / 1ps
// an accepted box beat passes the stage 1, 2 and 3 registers and the output register,
// which drives out_valid; throughput: one box per cycle in the four-stage test pipeline
// while in_stall is low; after reset or any register write the ray terms are rederived:
// a start cycle, the bit-serial reciprocal divider for each axis, then slope multiply,
// intercept multiply and subtract on the shared multiplier per axis pair, with in_stall high
// reset: synchronous active-low rst_n clears the ray registers and the valids
// ----------------------------------------------------------------------------
// ray_box_slope_test
// streams axis-aligned boxes against one ray by the ray-slope method
// ----------------------------------------------------------------------------
module ray_box_slope_test (
  input  logic                      clk,
  input  logic                      rst_n,
  // box beats
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rbst_pkg::box_t            in_data,
  // result beats
  output logic                      out_valid,
  input  logic                      out_stall,
  output rbst_pkg::res_t            out_data,
  // apb register port
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [rbst_pkg::AW-1:0]   cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  rbst_pkg::coord_t o_r [rbst_pkg::NAX];
  rbst_pkg::coord_t d_r [rbst_pkg::NAX];
  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic             cfg_hit_reg;

  assign cfg_pready  = 1'b1;
  assign cfg_idx     = cfg_paddr[4:2];
  assign cfg_wr      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_hit_reg = cfg_idx <= 3'(rbst_pkg::REG_DIR_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < rbst_pkg::NAX; a++) begin
        o_r[a] <= '0;
        d_r[a] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        rbst_pkg::REG_ORIGIN_X: o_r[0] <= cfg_pwdata;
        rbst_pkg::REG_ORIGIN_Y: o_r[1] <= cfg_pwdata;
        rbst_pkg::REG_ORIGIN_Z: o_r[2] <= cfg_pwdata;
        rbst_pkg::REG_DIR_X:    d_r[0] <= cfg_pwdata;
        rbst_pkg::REG_DIR_Y:    d_r[1] <= cfg_pwdata;
        rbst_pkg::REG_DIR_Z:    d_r[2] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rbst_pkg::REG_ORIGIN_X: cfg_prdata = o_r[0];
      rbst_pkg::REG_ORIGIN_Y: cfg_prdata = o_r[1];
      rbst_pkg::REG_ORIGIN_Z: cfg_prdata = o_r[2];
      rbst_pkg::REG_DIR_X:    cfg_prdata = d_r[0];
      rbst_pkg::REG_DIR_Y:    cfg_prdata = d_r[1];
      rbst_pkg::REG_DIR_Z:    cfg_prdata = d_r[2];
      default:                cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // derivation sequencer: reciprocals, slopes, intercepts, sign class
  // --------------------------------------------------------------------------
  rbst_pkg::drv_state_t state_r, state_nxt;
  logic                 stale_r;
  logic                 drv_start;
  logic [5:0]           cnt_r;
  logic [1:0]           axis_r;
  logic [2:0]           k_r;
  logic [rbst_pkg::CB:0]   rem_r, rem_nxt, rem_sh, div_d;
  logic [rbst_pkg::QW-1:0] q_r, q_nxt;
  logic                 div_last;
  rbst_pkg::prod_t      prod_r;
  rbst_pkg::coord_t     recip_r [rbst_pkg::NAX];
  rbst_pkg::coord_t     slope_r [rbst_pkg::NPR];
  rbst_pkg::coord_t     icpt_r  [rbst_pkg::NPR];
  rbst_pkg::sgn_t       sg_r    [rbst_pkg::NAX];
  rbst_pkg::sgn_t       sg_nxt  [rbst_pkg::NAX];

  assign drv_start = (state_r == rbst_pkg::ST_IDLE) && stale_r;
  assign div_last  = cnt_r == 6'(rbst_pkg::QW - 1);

  // a register write always wins over a start in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= 1'b1;
      state_r <= rbst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_hit_reg) stale_r <= 1'b1;
      else if (drv_start)        stale_r <= 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rbst_pkg::ST_IDLE: if (stale_r) state_nxt = rbst_pkg::ST_DIV;
      rbst_pkg::ST_DIV:  if (div_last && axis_r == 2'd2) state_nxt = rbst_pkg::ST_SMUL;
      rbst_pkg::ST_SMUL: state_nxt = rbst_pkg::ST_IMUL;
      rbst_pkg::ST_IMUL: state_nxt = rbst_pkg::ST_ISUB;
      rbst_pkg::ST_ISUB: begin
        state_nxt = (k_r == 3'(rbst_pkg::NPR - 1)) ? rbst_pkg::ST_IDLE : rbst_pkg::ST_SMUL;
      end
      default: state_nxt = rbst_pkg::ST_IDLE;
    endcase
  end

  // restoring division of 2^(2*FB) by |d|, one quotient bit a cycle
  always_comb begin
    div_d  = {1'b0, rbst_pkg::mag(d_r[axis_r])};
    rem_sh = {rem_r[rbst_pkg::CB-1:0], cnt_r == 6'd0};
    if (rem_sh >= div_d) begin
      rem_nxt = rem_sh - div_d;
      q_nxt   = {q_r[rbst_pkg::QW-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      q_nxt   = {q_r[rbst_pkg::QW-2:0], 1'b0};
    end
  end

  // sign class; an all-zero direction counts as pure +z
  always_comb begin
    for (int a = 0; a < rbst_pkg::NAX; a++) begin
      if (d_r[a][rbst_pkg::CB-1]) sg_nxt[a] = rbst_pkg::SG_M;
      else if (d_r[a] == '0)      sg_nxt[a] = rbst_pkg::SG_O;
      else                        sg_nxt[a] = rbst_pkg::SG_P;
    end
    if (sg_nxt[0] == rbst_pkg::SG_O && sg_nxt[1] == rbst_pkg::SG_O &&
        sg_nxt[2] == rbst_pkg::SG_O) begin
      sg_nxt[2] = rbst_pkg::SG_P;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rbst_pkg::ST_IDLE: begin
        if (stale_r) begin
          for (int a = 0; a < rbst_pkg::NAX; a++) sg_r[a] <= sg_nxt[a];
          axis_r <= '0;
          cnt_r  <= '0;
          rem_r  <= '0;
          q_r    <= '0;
          k_r    <= '0;
        end
      end
      rbst_pkg::ST_DIV: begin
        if (div_last) begin
          recip_r[axis_r] <= rbst_pkg::sat_mag(d_r[axis_r][rbst_pkg::CB-1],
                               {{(rbst_pkg::MW-rbst_pkg::QW){1'b0}}, q_nxt});
          axis_r <= axis_r + 2'd1;
          cnt_r  <= '0;
          rem_r  <= '0;
          q_r    <= '0;
        end else begin
          cnt_r <= cnt_r + 6'd1;
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
        end
      end
      rbst_pkg::ST_SMUL: begin
        prod_r <= rbst_pkg::mul_q(d_r[rbst_pkg::pair_j(k_r)], recip_r[rbst_pkg::pair_i(k_r)]);
      end
      rbst_pkg::ST_IMUL: begin
        slope_r[k_r] <= rbst_pkg::prod_sat(prod_r);
        prod_r <= rbst_pkg::mul_q(rbst_pkg::prod_sat(prod_r), o_r[rbst_pkg::pair_i(k_r)]);
      end
      rbst_pkg::ST_ISUB: begin
        icpt_r[k_r] <= rbst_pkg::ssub(o_r[rbst_pkg::pair_j(k_r)], rbst_pkg::prod_sat(prod_r));
        k_r <= k_r + 3'd1;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // box pipeline: select -> multiply -> saturate/subtract -> decide
  // one enable for all stages; it drops only when the output beat is held
  // --------------------------------------------------------------------------
  logic adv;
  logic in_acc;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv || stale_r || (state_r != rbst_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  rbst_pkg::coord_t lo [rbst_pkg::NAX];
  rbst_pkg::coord_t hi [rbst_pkg::NAX];
  assign lo[0] = in_data.box_min_x;
  assign lo[1] = in_data.box_min_y;
  assign lo[2] = in_data.box_min_z;
  assign hi[0] = in_data.box_max_x;
  assign hi[1] = in_data.box_max_y;
  assign hi[2] = in_data.box_max_z;

  // stage 1 next values
  rbst_pkg::coord_t s1_x_nxt [rbst_pkg::NPR];
  rbst_pkg::coord_t s1_y_nxt [rbst_pkg::NPR];
  rbst_pkg::coord_t s1_dd_nxt [rbst_pkg::NAX];
  logic [rbst_pkg::NPR-1:0] s1_act_nxt, s1_negj_nxt;
  logic [rbst_pkg::NAX-1:0] s1_dact_nxt;
  logic                     s1_bok_nxt;

  always_comb begin
    logic [1:0] pi;
    logic [1:0] pj;
    s1_bok_nxt = 1'b1;
    for (int a = 0; a < rbst_pkg::NAX; a++) begin
      if (sg_r[a] != rbst_pkg::SG_P && o_r[a] < lo[a]) s1_bok_nxt = 1'b0;
      if (sg_r[a] != rbst_pkg::SG_M && o_r[a] > hi[a]) s1_bok_nxt = 1'b0;
      s1_dact_nxt[a] = sg_r[a] != rbst_pkg::SG_O;
      s1_dd_nxt[a]   = rbst_pkg::ssub((sg_r[a] == rbst_pkg::SG_M) ? hi[a] : lo[a], o_r[a]);
    end
    for (int k = 0; k < rbst_pkg::NPR; k++) begin
      pi = rbst_pkg::pair_i(3'(k));
      pj = rbst_pkg::pair_j(3'(k));
      s1_act_nxt[k]  = sg_r[pi] != rbst_pkg::SG_O && sg_r[pj] != rbst_pkg::SG_O;
      s1_negj_nxt[k] = sg_r[pj] == rbst_pkg::SG_M;
      s1_x_nxt[k]    = (sg_r[pi] == rbst_pkg::SG_M) ? lo[pi] : hi[pi];
      s1_y_nxt[k]    = (sg_r[pj] == rbst_pkg::SG_M) ? hi[pj] : lo[pj];
    end
  end

  logic                     s1_v_r, s2_v_r, s3_v_r, out_v_r;
  rbst_pkg::coord_t         s1_x_r [rbst_pkg::NPR];
  rbst_pkg::coord_t         s1_y_r [rbst_pkg::NPR];
  rbst_pkg::coord_t         s1_dd_r [rbst_pkg::NAX];
  logic [rbst_pkg::NPR-1:0] s1_act_r, s1_negj_r, s2_act_r, s2_negj_r, s3_act_r, s3_negj_r;
  logic [rbst_pkg::NAX-1:0] s1_dact_r, s2_dact_r, s3_dact_r;
  logic                     s1_bok_r, s2_bok_r, s3_bok_r;
  rbst_pkg::prod_t          s2_sp_r [rbst_pkg::NPR];
  rbst_pkg::coord_t         s2_y_r  [rbst_pkg::NPR];
  rbst_pkg::prod_t          s2_tp_r [rbst_pkg::NAX];
  rbst_pkg::coord_t         s3_v_r_a [rbst_pkg::NPR];
  rbst_pkg::coord_t         s3_t_r  [rbst_pkg::NAX];
  rbst_pkg::res_t           out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_acc;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: box selects and origin offsets
      for (int k = 0; k < rbst_pkg::NPR; k++) begin
        s1_x_r[k] <= s1_x_nxt[k];
        s1_y_r[k] <= s1_y_nxt[k];
      end
      for (int a = 0; a < rbst_pkg::NAX; a++) s1_dd_r[a] <= s1_dd_nxt[a];
      s1_act_r  <= s1_act_nxt;
      s1_negj_r <= s1_negj_nxt;
      s1_dact_r <= s1_dact_nxt;
      s1_bok_r  <= s1_bok_nxt;
      // stage 2: products
      for (int k = 0; k < rbst_pkg::NPR; k++) begin
        s2_sp_r[k] <= rbst_pkg::mul_q(slope_r[k], s1_x_r[k]);
        s2_y_r[k]  <= s1_y_r[k];
      end
      for (int a = 0; a < rbst_pkg::NAX; a++) begin
        s2_tp_r[a] <= rbst_pkg::mul_q(s1_dd_r[a], recip_r[a]);
      end
      s2_act_r  <= s1_act_r;
      s2_negj_r <= s1_negj_r;
      s2_dact_r <= s1_dact_r;
      s2_bok_r  <= s1_bok_r;
      // stage 3: saturate, subtract far/near bound
      for (int k = 0; k < rbst_pkg::NPR; k++) begin
        s3_v_r_a[k] <= rbst_pkg::ssub(rbst_pkg::prod_sat(s2_sp_r[k]), s2_y_r[k]);
      end
      for (int a = 0; a < rbst_pkg::NAX; a++) s3_t_r[a] <= rbst_pkg::prod_sat(s2_tp_r[a]);
      s3_act_r  <= s2_act_r;
      s3_negj_r <= s2_negj_r;
      s3_dact_r <= s2_dact_r;
      s3_bok_r  <= s2_bok_r;
      // stage 4: decision and entry distance
      out_data_r <= out_data_nxt;
    end
  end

  // slope tests and the largest near-plane parameter
  always_comb begin
    rbst_pkg::coord_t w;
    rbst_pkg::coord_t best;
    logic             first;
    logic             hit;
    hit = s3_bok_r;
    for (int k = 0; k < rbst_pkg::NPR; k++) begin
      w = rbst_pkg::sadd(s3_v_r_a[k], icpt_r[k]);
      if (s3_act_r[k]) begin
        if (s3_negj_r[k] ? (w > 0) : (w < 0)) hit = 1'b0;
      end
    end
    best  = '0;
    first = 1'b1;
    for (int a = 0; a < rbst_pkg::NAX; a++) begin
      if (s3_dact_r[a]) begin
        if (first || s3_t_r[a] > best) best = s3_t_r[a];
        first = 1'b0;
      end
    end
    out_data_nxt.hit            = hit;
    out_data_nxt.entry_distance = hit ? best : '0;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_box_while_deriving: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rbst_pkg::ST_IDLE || stale_r) |-> in_stall)
    else $error("box beat could enter while ray terms are being derived");

  a_write_marks_stale: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_hit_reg) |=> stale_r)
    else $error("register write did not mark derived terms stale");

  a_miss_zero_distance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.entry_distance == '0))
    else $error("missed box carries a nonzero entry distance");

endmodule
